// ===== rtl/core/rbsi_pkg.sv =====
package rbsi_pkg;

  localparam int unsigned NumAxes  = 3;
  localparam int unsigned NumLanes = 2 * NumAxes;
  localparam int unsigned QuoW     = 33;
  localparam int unsigned NumCells = QuoW;
  localparam int unsigned DivW     = 49;
  localparam int unsigned HighW    = DivW - QuoW;

  localparam logic signed [31:0] IntMin = 32'sh8000_0000;
  localparam logic signed [31:0] IntMax = 32'sh7fff_ffff;

  localparam logic [0:0] RegThreshold = 1'b0;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] direction_x;
    logic signed [31:0] direction_y;
    logic signed [31:0] direction_z;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
  } ray_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] t_enter;
    logic signed [31:0] t_leave;
  } res_t;

  // One divider lane as it moves through the cell row.
  typedef struct packed {
    logic [31:0]     rem;
    logic [QuoW-1:0] low;
    logic [QuoW-1:0] quo;
    logic [31:0]     den;
    logic            neg;
    logic            ovf;
  } lane_t;

  // Per-item control that travels alongside the lanes.
  typedef struct packed {
    logic               valid;
    logic [NumAxes-1:0] active;
    logic [NumAxes-1:0] in_slab;
  } side_t;

endpackage

// ===== rtl/core/rbsi_div_cell.sv =====
module rbsi_div_cell
  import rbsi_pkg::*;
(
  input  logic  clk_i,
  input  lane_t lane_i,
  output lane_t lane_o
);

  logic [32:0] trial;
  lane_t       lane_d;
  lane_t       lane_q;

  // One restoring step: bring in the next dividend bit and try a subtract.
  always_comb begin
    trial  = {lane_i.rem, lane_i.low[QuoW-1]};
    lane_d = lane_i;
    lane_d.low = {lane_i.low[QuoW-2:0], 1'b0};
    if (trial >= {1'b0, lane_i.den}) begin
      lane_d.rem = 32'(trial - {1'b0, lane_i.den});
      lane_d.quo = {lane_i.quo[QuoW-2:0], 1'b1};
    end else begin
      lane_d.rem = trial[31:0];
      lane_d.quo = {lane_i.quo[QuoW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

  assign lane_o = lane_q;

endmodule

// ===== rtl/core/rbsi_combine.sv =====
module rbsi_combine
  import rbsi_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  lane_t lane_i [NumLanes],
  input  side_t side_i,
  output logic  valid_o,
  output res_t  res_o
);

  logic signed [31:0] sat      [NumLanes];
  logic signed [31:0] ent_d    [NumAxes];
  logic signed [31:0] lev_d    [NumAxes];
  logic signed [31:0] ent_q    [NumAxes];
  logic signed [31:0] lev_q    [NumAxes];
  logic               ok_d, ok_q, va_q, valid_q;
  logic signed [31:0] te, tl;
  res_t               res_d, res_q;

  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      if (lane_i[l].neg) begin
        if (lane_i[l].ovf || lane_i[l].quo >= 33'h0_8000_0000) begin
          sat[l] = IntMin;
        end else begin
          sat[l] = 32'(-$signed({1'b0, lane_i[l].quo}));
        end
      end else begin
        if (lane_i[l].ovf || lane_i[l].quo > 33'h0_7fff_ffff) begin
          sat[l] = IntMax;
        end else begin
          sat[l] = $signed(lane_i[l].quo[31:0]);
        end
      end
    end
    for (int a = 0; a < NumAxes; a++) begin
      if (!side_i.active[a]) begin
        ent_d[a] = IntMin;
        lev_d[a] = IntMax;
      end else if (sat[2*a] < sat[2*a+1]) begin
        ent_d[a] = sat[2*a];
        lev_d[a] = sat[2*a+1];
      end else begin
        ent_d[a] = sat[2*a+1];
        lev_d[a] = sat[2*a];
      end
    end
    ok_d = &(side_i.active | side_i.in_slab);
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    lev_q <= lev_d;
    ok_q  <= ok_d;
  end

  always_comb begin
    te = ent_q[0];
    tl = lev_q[0];
    for (int a = 1; a < NumAxes; a++) begin
      if (ent_q[a] > te) te = ent_q[a];
      if (lev_q[a] < tl) tl = lev_q[a];
    end
    if (ok_q && te < tl) begin
      res_d.hit     = 1'b1;
      res_d.t_enter = te;
      res_d.t_leave = tl;
    end else begin
      res_d.hit     = 1'b0;
      res_d.t_enter = '0;
      res_d.t_leave = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      va_q    <= side_i.valid;
      valid_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== rtl/core/ray_box_slab_intersection_core.sv =====
// Ray against axis-aligned box, slab method, Q16.16 fixed point.
// Throughput: one ray per cycle; busy_o stays low, the row of divider cells is fully pipelined.
// The pipeline is the 33-cell restoring divider row plus one setup and two combine stages.
// Reset (rst_ni low, asynchronous) empties the pipeline and sets the threshold to 1.
// The receiver cannot stall; every result is shown for exactly one cycle.
module ray_box_slab_intersection_core
  import rbsi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  ray_t        ray_i,
  output logic        result_valid_o,
  output res_t        result_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  // Configuration register. Only address bit 2 is decoded: addresses 0 to 3 all reach the
  // register; addresses 4 to 7 read as zero and ignore writes.
  logic [30:0] thr_q;
  logic        cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 31'd1;
    end else if (cfg_wr && paddr_i[2] == RegThreshold) begin
      thr_q <= pwdata_i[30:0];
    end
  end

  assign prdata_o = (paddr_i[2] == RegThreshold) ? {1'b0, thr_q} : '0;

  // The pipeline never stalls, so every start is a transfer.
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // Setup stage. Each axis gives two lanes, one per slab plane. A lane
  // divides the magnitude of (plane - origin) * 2^16 by the magnitude of
  // the direction; the sign is restored afterwards, which matches
  // truncation toward zero. A quotient that cannot fit in 33 bits is
  // flagged up front so the cell row only needs 33 steps.
  logic signed [31:0] org [NumAxes];
  logic signed [31:0] dir [NumAxes];
  logic signed [31:0] lo  [NumAxes];
  logic signed [31:0] hi  [NumAxes];

  assign org[0] = ray_i.origin_x;
  assign org[1] = ray_i.origin_y;
  assign org[2] = ray_i.origin_z;
  assign dir[0] = ray_i.direction_x;
  assign dir[1] = ray_i.direction_y;
  assign dir[2] = ray_i.direction_z;
  assign lo[0]  = ray_i.box_min_x;
  assign lo[1]  = ray_i.box_min_y;
  assign lo[2]  = ray_i.box_min_z;
  assign hi[0]  = ray_i.box_max_x;
  assign hi[1]  = ray_i.box_max_y;
  assign hi[2]  = ray_i.box_max_z;

  lane_t       prep_d [NumLanes];
  side_t       side_d;
  logic signed [32:0] diff;
  logic [32:0] mag;
  logic [DivW-1:0] num;
  logic [31:0] dmag [NumAxes];

  always_comb begin
    side_d.valid = accept;
    for (int a = 0; a < NumAxes; a++) begin
      // The most negative direction gives a magnitude of exactly 2^31.
      dmag[a] = dir[a][31] ? 32'(~dir[a] + 32'sd1) : dir[a];
      side_d.active[a]  = dmag[a] > {1'b0, thr_q};
      side_d.in_slab[a] = (org[a] > lo[a]) && (org[a] < hi[a]);
    end
    diff = '0;
    mag  = '0;
    num  = '0;
    for (int l = 0; l < NumLanes; l++) begin
      if (l % 2 == 0) begin
        diff = {lo[l/2][31], lo[l/2]} - {org[l/2][31], org[l/2]};
      end else begin
        diff = {hi[l/2][31], hi[l/2]} - {org[l/2][31], org[l/2]};
      end
      mag = diff[32] ? 33'(-diff) : diff;
      num = {mag, 16'b0};
      prep_d[l].rem = {16'b0, num[DivW-1:QuoW]};
      prep_d[l].low = num[QuoW-1:0];
      prep_d[l].quo = '0;
      prep_d[l].den = dmag[l/2];
      prep_d[l].neg = diff[32] ^ dir[l/2][31];
      prep_d[l].ovf = {16'b0, num[DivW-1:QuoW]} >= dmag[l/2];
    end
  end

  // Lane data through the cell row; stage 0 is the setup register.
  lane_t prep_q [NumLanes];
  lane_t stage [NumCells+1][NumLanes];
  side_t side_q [NumCells+1];

  always_ff @(posedge clk_i) begin
    prep_q <= prep_d;
  end

  assign stage[0] = prep_q;

  // The control word keeps step with the cells.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= NumCells; s++) begin
        side_q[s] <= '0;
      end
    end else begin
      side_q[0] <= side_d;
      for (int s = 1; s <= NumCells; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  for (genvar s = 0; s < NumCells; s++) begin : g_cell
    for (genvar l = 0; l < NumLanes; l++) begin : g_lane
      rbsi_div_cell u_cell (
        .clk_i  (clk_i),
        .lane_i (stage[s][l]),
        .lane_o (stage[s+1][l])
      );
    end
  end

  // Saturation, per-axis ordering, then the max/min reduction and hit test.
  rbsi_combine u_combine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .lane_i  (stage[NumCells]),
    .side_i  (side_q[NumCells]),
    .valid_o (result_valid_o),
    .res_o   (result_o)
  );

  // A miss always reports zero parameters.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.hit |-> result_o.t_enter == 0 && result_o.t_leave == 0)
    else $error("miss with nonzero parameters");

  // A hit always has a strictly ordered interval.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.hit |-> result_o.t_enter < result_o.t_leave)
    else $error("hit with empty interval");

  // A threshold write lands in the register on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr && paddr_i[2] == RegThreshold |=> thr_q == $past(pwdata_i[30:0]))
    else $error("threshold write lost");

endmodule

// ===== tb/sv/ray_box_slab_intersection_core_test.sv =====
`timescale 1ns / 1ps

module ray_box_slab_intersection_core_test
  import rbsi_pkg::*;
();

  localparam int unsigned LatencyCycles = 36;
  localparam int unsigned StallLimit    = 2000;
  localparam logic [2:0]  AddrThreshold = 3'(4 * RegThreshold);

  // The scoreboard keeps its own copy of the threshold register and predicts
  // every ray test from it. Expected results wait in order in a queue.
  class slab_scoreboard;
    logic [30:0] threshold;
    res_t        pending_hits[$];
    int          mismatches;

    function new();
      threshold  = 31'd1;
      mismatches = 0;
    endfunction

    // One slab crossing: ((plane - origin) * 2^16) / direction, truncated
    // toward zero, then saturated to the Q16.16 range.
    function automatic longint crossing_time(longint plane, longint org, longint dir);
      longint q;
      q = ((plane - org) * 65536) / dir;
      if (q < longint'(IntMin)) return longint'(IntMin);
      if (q > longint'(IntMax)) return longint'(IntMax);
      return q;
    endfunction

    function automatic res_t predict_hit(ray_t r);
      longint org[3], dir[3], lo[3], hi[3];
      longint t_in, t_out, a, b, mag;
      bit     ok;
      res_t   res;
      org = '{r.origin_x, r.origin_y, r.origin_z};
      dir = '{r.direction_x, r.direction_y, r.direction_z};
      lo  = '{r.box_min_x, r.box_min_y, r.box_min_z};
      hi  = '{r.box_max_x, r.box_max_y, r.box_max_z};
      t_in  = longint'(IntMin);
      t_out = longint'(IntMax);
      ok    = 1'b1;
      for (int ax = 0; ax < 3; ax++) begin
        if (!ok) break;
        mag = dir[ax] < 0 ? -dir[ax] : dir[ax];
        if (mag > longint'(threshold)) begin
          a = crossing_time(lo[ax], org[ax], dir[ax]);
          b = crossing_time(hi[ax], org[ax], dir[ax]);
          if (a > b) begin
            mag = a; a = b; b = mag;
          end
          if (a > t_in) t_in = a;
          if (b < t_out) t_out = b;
        end else begin
          // A near-parallel axis only needs the origin strictly inside the slab.
          ok = org[ax] > lo[ax] && org[ax] < hi[ax];
        end
      end
      res = '0;
      if (ok && t_in < t_out) begin
        res.hit     = 1'b1;
        res.t_enter = 32'(t_in);
        res.t_leave = 32'(t_out);
      end
      return res;
    endfunction

    function void note_ray(ray_t r);
      pending_hits = {pending_hits, predict_hit(r)};
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending_hits.pop_front();
      if (got.hit !== want.hit || got.t_enter !== want.t_enter ||
          got.t_leave !== want.t_leave) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected hit=%0d enter=%0d leave=%0d, ",
                    "got hit=%0d enter=%0d leave=%0d"},
                   want.hit, want.t_enter, want.t_leave, got.hit, got.t_enter, got.t_leave);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  ray_t        ray_i;
  logic        result_valid_o;
  res_t        result_o;
  logic        psel_i;
  logic        penable_i;
  logic        pwrite_i;
  logic [2:0]  paddr_i;
  logic [31:0] pwdata_i;
  logic [31:0] prdata_o;
  logic        pready_o;

  slab_scoreboard sb;
  int unsigned    stall_cycles;
  bit             no_idle;

  ray_box_slab_intersection_core i_dut (.*);

  // 20 ns clock.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Accepted ray transfers are noted and result transfers are checked at the
  // rising edge. The watchdog counts cycles in which no transfer happens.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note_ray(ray_i);
      if (result_valid_o) sb.check_result(result_o);
      if ((start_i && !busy_o) || result_valid_o || psel_i) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles > StallLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Threshold write through the APB port: setup cycle, then access cycle.
  // The block must be idle, so wait for all results plus the pipeline depth.
  task automatic write_threshold(logic [30:0] value);
    while (sb.pending_hits.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles + 2) @(posedge clk_i);
    psel_i    <= 1'b1;
    pwrite_i  <= 1'b1;
    paddr_i   <= AddrThreshold;
    pwdata_i  <= {1'b0, value};
    @(posedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
    sb.threshold = value;
  endtask

  // Drives one ray and holds start until the transfer is accepted. Random
  // idle cycles come first unless the no-idle stretch is on.
  task automatic send_ray(ray_t r);
    if (!no_idle)
      while ($urandom_range(99) < 37) begin
        start_i <= 1'b0;
        @(posedge clk_i);
      end
    start_i <= 1'b1;
    ray_i   <= r;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic pause_ray_stream();
    start_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random Q16.16 value: mostly small coordinates so rays actually meet
  // boxes, with some full-range and extreme values mixed in.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0:       return $urandom();
      1:       return $urandom_range(1) ? IntMax : IntMin;
      2:       return 32'($signed($urandom_range(64)) - 32);
      default: return 32'($signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000);
    endcase
  endfunction

  // A ray aimed at a box around its target, so that hits are common.
  function automatic ray_t rand_ray();
    ray_t r;
    logic signed [31:0] c, h;
    r = '0;
    for (int ax = 0; ax < 3; ax++) begin
      c = rand_coord();
      h = 32'($urandom_range(32'h0008_0000));
      case (ax)
        0: begin
          r.origin_x = rand_coord(); r.direction_x = rand_coord();
          r.box_min_x = c - h; r.box_max_x = c + h;
        end
        1: begin
          r.origin_y = rand_coord(); r.direction_y = rand_coord();
          r.box_min_y = c - h; r.box_max_y = c + h;
        end
        default: begin
          r.origin_z = rand_coord(); r.direction_z = rand_coord();
          r.box_min_z = c - h; r.box_max_z = c + h;
        end
      endcase
    end
    // Aim the direction from the origin toward the box center most of the time.
    if ($urandom_range(3) != 0) begin
      r.direction_x = (r.box_min_x >>> 1) + (r.box_max_x >>> 1) - r.origin_x;
      r.direction_y = (r.box_min_y >>> 1) + (r.box_max_y >>> 1) - r.origin_y;
      r.direction_z = (r.box_min_z >>> 1) + (r.box_max_z >>> 1) - r.origin_z;
    end
    // Some noise: inverted boxes and fully random fields.
    if ($urandom_range(9) == 0) r.box_min_y = r.box_max_y + 32'sd1;
    if ($urandom_range(19) == 0) r = {$urandom(), $urandom(), $urandom(), $urandom(),
                                      $urandom(), $urandom(), $urandom(), $urandom(),
                                      $urandom(), $urandom(), $urandom(), $urandom()};
    return r;
  endfunction

  task automatic run_directed();
    ray_t r;
    // Straight ray along x through a unit box: a plain hit.
    r = '0;
    r.origin_x = -32'sh0005_0000; r.direction_x = 32'sh0001_0000;
    r.box_min_x = -32'sh0001_0000; r.box_max_x = 32'sh0001_0000;
    r.box_min_y = -32'sh0001_0000; r.box_max_y = 32'sh0001_0000;
    r.box_min_z = -32'sh0001_0000; r.box_max_z = 32'sh0001_0000;
    send_ray(r);
    // Same ray pointing away, negative direction.
    r.direction_x = -32'sh0001_0000;
    send_ray(r);
    // Parallel axis with origin on the slab plane: not strictly inside.
    r.direction_x = 32'sh0001_0000; r.origin_y = 32'sh0001_0000;
    send_ray(r);
    // Zero direction on every axis, origin inside: hit over the whole range.
    r = '0;
    r.box_min_x = -32'sd5; r.box_max_x = 32'sd5;
    r.box_min_y = -32'sd5; r.box_max_y = 32'sd5;
    r.box_min_z = -32'sd5; r.box_max_z = 32'sd5;
    send_ray(r);
    // Inverted box on a parallel axis.
    r.box_min_z = 32'sd6;
    send_ray(r);
    // Inverted box on a crossing axis.
    r.box_min_z = 32'sd5; r.box_max_z = -32'sd5; r.direction_z = 32'sh0001_0000;
    send_ray(r);
    // Most negative direction and saturating quotients.
    r = '0;
    r.origin_x = IntMax; r.direction_x = IntMin;
    r.box_min_x = IntMin; r.box_max_x = IntMax;
    r.direction_y = 32'sd2; r.box_min_y = IntMin; r.box_max_y = IntMax;
    r.direction_z = IntMax; r.origin_z = IntMin; r.box_min_z = IntMin; r.box_max_z = IntMax;
    send_ray(r);
    // Directions just at and just above the threshold of one.
    r = '0;
    r.box_min_x = -32'sd100; r.box_max_x = 32'sd100;
    r.box_min_y = -32'sd100; r.box_max_y = 32'sd100;
    r.box_min_z = -32'sd100; r.box_max_z = 32'sd100;
    r.direction_x = 32'sd1; r.direction_y = -32'sd1; r.direction_z = 32'sd2;
    send_ray(r);
    r.direction_z = -32'sd2;
    send_ray(r);
    // All fields at the extremes.
    send_ray('1);
    send_ray({12{IntMin}});
    send_ray({12{IntMax}});
    send_ray('0);
    pause_ray_stream();
  endtask

  initial begin
    logic [30:0] thresholds[5];
    sb           = new();
    stall_cycles = 0;
    no_idle      = 1'b0;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    ray_i        = '0;
    psel_i       = 1'b0;
    penable_i    = 1'b0;
    pwrite_i     = 1'b0;
    paddr_i      = '0;
    pwdata_i     = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset threshold of one first, then the directed rays under the extremes.
    run_directed();
    write_threshold('1);
    run_directed();
    write_threshold('0);
    run_directed();

    thresholds = '{31'd1, 31'h0000_8000, 31'h0001_0000, 31'h7fff_ffff, 31'd0};
    foreach (thresholds[p]) begin
      write_threshold(p == 0 ? 31'($urandom()) : thresholds[p]);
      for (int n = 0; n < 200; n++) begin
        // One long stretch of back-to-back rays in the middle phase.
        no_idle = (p == 2 && n >= 50 && n < 150);
        send_ray(rand_ray());
      end
      pause_ray_stream();
    end

    while (sb.pending_hits.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles + 4) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_hits.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/rbsi_pkg.sv
rtl/core/rbsi_div_cell.sv
rtl/core/rbsi_combine.sv
rtl/core/ray_box_slab_intersection_core.sv
tb/sv/ray_box_slab_intersection_core_test.sv
